/* rtl/lae_pkg.sv */
package lae_pkg;

  // Field widths fixed by the request format.
  localparam int OPCODE_W      = 2;
  localparam int CELL_ADDR_W   = 5;
  // Wide enough to compare a cell address against any grid size up to 256.
  localparam int ADDR_EXT_W    = 9;
  localparam int NB_COUNT_W    = 4;

  // Default grid size.
  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 32;

  // Request opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_STEP   = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic clr_wr;     // write a dead row during the clearing pass
    logic cell_rd;    // read the row of the addressed cell
    logic cell_mod;   // update the addressed cell and record the result
    logic gen_rd0;    // start a generation: read row 0
    logic gen_prime;  // load row 0 into the window, read row 1
    logic gen_row;    // compute and write back one row of the next generation
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_step;    // request at the input port is a generation step
    logic cnt_last;   // row counter is at the last row
    logic out_free;   // output register can take a result this cycle
  } sts_t;

  // Number of live cells among eight neighbours.
  function automatic logic [NB_COUNT_W-1:0] neighbour_sum(input logic [7:0] nb);
    logic [NB_COUNT_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + NB_COUNT_W'(nb[k]);
    end
    return sum;
  endfunction

  // B3/S23: birth on three, survival on two or three.
  function automatic logic life_rule(input logic alive, input logic [NB_COUNT_W-1:0] cnt);
    logic nxt;
    if (alive) begin
      nxt = (cnt == NB_COUNT_W'(2)) || (cnt == NB_COUNT_W'(3));
    end else begin
      nxt = (cnt == NB_COUNT_W'(3));
    end
    return nxt;
  endfunction

endpackage

/* rtl/lae_datapath.sv */
module lae_datapath
  import lae_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [CELL_ADDR_W-1:0] in_cell_row,
  input  logic [CELL_ADDR_W-1:0] in_cell_col,
  input  logic                   in_write_value,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_cell_alive
);

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int PAD_W = GRID_COLS + 2;

  // Grid storage: one word per row, one bit per cell.
  logic [GRID_COLS-1:0] life_mem [GRID_ROWS];

  logic                   mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic [GRID_COLS-1:0]   mem_wdata;
  logic                   mem_re;
  logic [ROW_W-1:0]       mem_raddr;
  logic [GRID_COLS-1:0]   rd_row_r;

  // Captured request.
  opcode_t                op_r;
  logic [CELL_ADDR_W-1:0] row_r;
  logic [CELL_ADDR_W-1:0] col_r;
  logic                   val_r;

  // Row counter shared by the clearing pass and the generation sweep.
  logic [ROW_W-1:0]       cnt_r, cnt_nxt;
  logic [ROW_W:0]         cnt_plus2;
  logic                   rd_ahead_ok;

  // Three-row window for the generation sweep.
  logic [GRID_COLS-1:0]   prev_r, cur_r;
  logic [GRID_COLS-1:0]   nxt_row;
  logic [GRID_COLS-1:0]   gen_new_row;

  // Cell access.
  logic [ADDR_EXT_W-1:0]  row_ext, col_ext;
  logic [ROW_W-1:0]       row_idx;
  logic [COL_W-1:0]       col_idx;
  logic                   cell_ok;
  logic                   cell_old, cell_new;
  logic [GRID_COLS-1:0]   cell_new_row;

  // Result and output register.
  logic                   res_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_alive_r;

  // Address decode of the captured cell.
  assign row_ext = {{(ADDR_EXT_W-CELL_ADDR_W){1'b0}}, row_r};
  assign col_ext = {{(ADDR_EXT_W-CELL_ADDR_W){1'b0}}, col_r};
  assign row_idx = row_ext[ROW_W-1:0];
  assign col_idx = col_ext[COL_W-1:0];
  assign cell_ok = (row_ext < ADDR_EXT_W'(GRID_ROWS)) && (col_ext < ADDR_EXT_W'(GRID_COLS));

  // Cell update within the row just read.
  assign cell_old = cell_ok ? rd_row_r[col_idx] : 1'b0;

  always_comb begin
    case (op_r)
      OP_WRITE:  cell_new = val_r;
      OP_TOGGLE: cell_new = ~cell_old;
      default:   cell_new = cell_old;
    endcase
  end

  always_comb begin
    cell_new_row = rd_row_r;
    if (cell_ok) begin
      cell_new_row[col_idx] = cell_new;
    end
  end

  // Row counter and read-ahead bound.
  assign cnt_plus2   = {1'b0, cnt_r} + (ROW_W+1)'(2);
  assign rd_ahead_ok = cnt_plus2 < (ROW_W+1)'(GRID_ROWS);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd_i.clr_wr || cmd_i.gen_row) begin
      cnt_nxt = cnt_r + ROW_W'(1);
    end else if (cmd_i.gen_rd0) begin
      cnt_nxt = '0;
    end
  end

  // The row below the last one is dead.
  assign nxt_row = sts_o.cnt_last ? '0 : rd_row_r;

  // One lane per column: count neighbours in the window and apply the rule.
  always_comb begin
    logic [PAD_W-1:0] p_pad;
    logic [PAD_W-1:0] c_pad;
    logic [PAD_W-1:0] n_pad;
    logic [7:0]       nb;
    p_pad = {1'b0, prev_r, 1'b0};
    c_pad = {1'b0, cur_r, 1'b0};
    n_pad = {1'b0, nxt_row, 1'b0};
    for (int j = 0; j < GRID_COLS; j++) begin
      nb = {p_pad[j +: 3], c_pad[j], c_pad[j+2], n_pad[j +: 3]};
      gen_new_row[j] = life_rule(c_pad[j+1], neighbour_sum(nb));
    end
  end

  // Memory port control.
  assign mem_we = cmd_i.clr_wr || cmd_i.gen_row ||
                  (cmd_i.cell_mod && cell_ok && (op_r != OP_READ));
  assign mem_waddr = cmd_i.cell_mod ? row_idx : cnt_r;

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_wdata = '0;
    end else if (cmd_i.gen_row) begin
      mem_wdata = gen_new_row;
    end else begin
      mem_wdata = cell_new_row;
    end
  end

  assign mem_re = (cmd_i.cell_rd && cell_ok) || cmd_i.gen_rd0 || cmd_i.gen_prime ||
                  (cmd_i.gen_row && rd_ahead_ok);

  always_comb begin
    if (cmd_i.cell_rd) begin
      mem_raddr = row_idx;
    end else if (cmd_i.gen_rd0) begin
      mem_raddr = '0;
    end else if (cmd_i.gen_prime) begin
      mem_raddr = ROW_W'(1);
    end else begin
      mem_raddr = cnt_plus2[ROW_W-1:0];
    end
  end

  // Grid memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      life_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= life_mem[mem_raddr];
    end
  end

  // Request capture, window shift, result bit and output data.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r  <= opcode_t'(in_opcode);
      row_r <= in_cell_row;
      col_r <= in_cell_col;
      val_r <= in_write_value;
    end
    if (cmd_i.gen_prime) begin
      prev_r <= '0;
      cur_r  <= rd_row_r;
    end else if (cmd_i.gen_row) begin
      prev_r <= cur_r;
      cur_r  <= nxt_row;
    end
    if (cmd_i.cell_mod) begin
      res_r <= cell_ok && cell_new;
    end else if (cmd_i.gen_rd0) begin
      res_r <= 1'b0;
    end
    if (cmd_i.load_out) begin
      out_alive_r <= res_r;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_i.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Status and outputs.
  assign sts_o.is_step  = (in_opcode == OP_STEP);
  assign sts_o.cnt_last = (cnt_r == ROW_W'(GRID_ROWS - 1));
  assign sts_o.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_alive_r;

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded into a full output register");

  // Write-back and read-ahead never hit the same row in one cycle.
  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("grid memory read and write at the same row");

  // The sweep visits consecutive rows.
  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.gen_row && !sts_o.cnt_last) |=> (cnt_r == $past(cnt_r) + ROW_W'(1)))
    else $error("generation sweep skipped a row");
`endif

endmodule

/* rtl/lae_controller.sv */
module lae_controller
  import lae_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_CELL_RD   = 8'b0000_0100,
    S_CELL_MOD  = 8'b0000_1000,
    S_GEN_RD0   = 8'b0001_0000,
    S_GEN_PRIME = 8'b0010_0000,
    S_GEN_ROW   = 8'b0100_0000,
    S_RESULT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.capture = accept;
        if (accept) begin
          state_nxt = sts_i.is_step ? S_GEN_RD0 : S_CELL_RD;
        end
      end
      S_CELL_RD: begin
        cmd_o.cell_rd = 1'b1;
        state_nxt     = S_CELL_MOD;
      end
      S_CELL_MOD: begin
        cmd_o.cell_mod = 1'b1;
        state_nxt      = S_RESULT;
      end
      S_GEN_RD0: begin
        cmd_o.gen_rd0 = 1'b1;
        state_nxt     = S_GEN_PRIME;
      end
      S_GEN_PRIME: begin
        cmd_o.gen_prime = 1'b1;
        state_nxt       = S_GEN_ROW;
      end
      S_GEN_ROW: begin
        cmd_o.gen_row = 1'b1;
        if (sts_i.cnt_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request accepted while another is in work");
`endif

endmodule

/* rtl/life_automaton_engine.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_opcode, in_cell_row, in_cell_col, in_write_value
// out_      output     out_valid/out_ready  out_cell_alive
//
// A write, toggle or read request passes through capture, row read, cell update and result.
// A step request reads row 0, primes the window, then sweeps; the sweep computes one whole row
// per cycle and is bounded by the single read and single write port of the row memory.
// After reset a clearing pass writes every row dead before in_ready rises.
// A finished result sits in the output register; a stalled output does not hold back the work
// on the following result, but holds back its delivery and the acceptance of the next request.
module life_automaton_engine
  import lae_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [CELL_ADDR_W-1:0] in_cell_row,
  input  logic [CELL_ADDR_W-1:0] in_cell_col,
  input  logic                   in_write_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_cell_alive
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of requests, clearing pass and generation sweep.
  lae_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // Grid memory, row window, rule lanes and output register.
  lae_datapath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_opcode      (in_opcode),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_write_value (in_write_value),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_cell_alive (out_cell_alive)
  );

endmodule

/* sim/life_checker.sv */
module life_checker
  import lae_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [CELL_ADDR_W-1:0] in_cell_row,
  input  logic [CELL_ADDR_W-1:0] in_cell_col,
  input  logic                   in_write_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_cell_alive,
  output logic [15:0]            outstanding,
  output int                     mismatches
);

  timeunit 1ns;
  timeprecision 1ps;

  // One pending answer: the request that caused it and the state it must report.
  typedef struct {
    opcode_t                op;
    logic [CELL_ADDR_W-1:0] row;
    logic [CELL_ADDR_W-1:0] col;
    logic                   alive;
  } cell_answer_t;

  // Shadow copy of the grid and the answers still owed by the block.
  logic         shadow_grid [GRID_ROWS][GRID_COLS];
  cell_answer_t owed_answers_q [$];
  int           mismatch_cnt;

  // Cells beyond the edge count as dead; there is no wrap-around.
  function automatic logic shadow_cell(input int r, input int c);
    if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS) begin
      return 1'b0;
    end
    return shadow_grid[r][c];
  endfunction

  // Counts every neighbourhood from the current generation before touching any cell.
  task automatic advance_shadow_generation();
    logic [NB_COUNT_W-1:0] live_nb [GRID_ROWS][GRID_COLS];
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        live_nb[r][c] = '0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              live_nb[r][c] = live_nb[r][c] + NB_COUNT_W'(shadow_cell(r + dr, c + dc));
            end
          end
        end
      end
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        if (shadow_grid[r][c]) begin
          shadow_grid[r][c] = (live_nb[r][c] == 2) || (live_nb[r][c] == 3);
        end else begin
          shadow_grid[r][c] = (live_nb[r][c] == 3);
        end
      end
    end
  endtask

  // Applies one request to the shadow grid and returns the state the block must report.
  task automatic predict_cell_alive(input opcode_t op, input logic [CELL_ADDR_W-1:0] row,
                                    input logic [CELL_ADDR_W-1:0] col, input logic wr_val,
                                    output logic alive);
    alive = 1'b0;
    if (op == OP_STEP) begin
      advance_shadow_generation();
    end else if (row < GRID_ROWS && col < GRID_COLS) begin
      if (op == OP_WRITE) begin
        shadow_grid[row][col] = wr_val;
      end else if (op == OP_TOGGLE) begin
        shadow_grid[row][col] = ~shadow_grid[row][col];
      end
      alive = shadow_grid[row][col];
    end
  endtask

  // Track requests going in and compare each result with the oldest owed answer.
  always @(posedge clk) begin
    cell_answer_t answer;
    if (!rst_n) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        for (int c = 0; c < GRID_COLS; c++) begin
          shadow_grid[r][c] = 1'b0;
        end
      end
      owed_answers_q.delete();
      mismatch_cnt = 0;
    end else begin
      if (in_valid && in_ready) begin
        answer.op  = opcode_t'(in_opcode);
        answer.row = in_cell_row;
        answer.col = in_cell_col;
        predict_cell_alive(answer.op, in_cell_row, in_cell_col, in_write_value, answer.alive);
        owed_answers_q.push_back(answer);
      end
      if (out_valid && out_ready) begin
        if (owed_answers_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result with no request pending: cell_alive=%0b",
                     $realtime, out_cell_alive);
          end
        end else begin
          answer = owed_answers_q.pop_front();
          if (out_cell_alive !== answer.alive) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: %s row=%0d col=%0d: cell_alive expected %0b, got %0b",
                       $realtime, answer.op.name(), answer.row, answer.col,
                       answer.alive, out_cell_alive);
            end
          end
        end
      end
    end
    outstanding <= 16'(owed_answers_q.size());
    mismatches  <= mismatch_cnt;
  end

endmodule

/* sim/tb_life_automaton_engine.sv */
module tb_life_automaton_engine
  import lae_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 580;

  // Receiver stall patterns.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_BURSTY,
    RX_MOSTLY
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [OPCODE_W-1:0]    in_opcode;
  logic [CELL_ADDR_W-1:0] in_cell_row;
  logic [CELL_ADDR_W-1:0] in_cell_col;
  logic                   in_write_value;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_cell_alive;
  logic [15:0]            outstanding;
  int                     mismatches;

  int       cycle_cnt = 0;
  int       sent_cnt = 0;
  int       burst_left = 0;
  int       stall_left;
  int       mode_left;
  rx_mode_t rx_mode;

  life_automaton_engine u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive)
  );

  life_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive),
    .outstanding    (outstanding),
    .mismatches     (mismatches)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver switches among the stall patterns at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      mode_left  = 0;
      rx_mode    = RX_ALWAYS;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_BURSTY: begin
            out_ready <= 1'b1;
            stall_left = $urandom_range(1, 15);
          end
          default:   out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Presents one request and holds it until accepted; bursts end in a random gap.
  task automatic issue_request(input opcode_t op, input logic [CELL_ADDR_W-1:0] row,
                               input logic [CELL_ADDR_W-1:0] col, input logic wr_val);
    int gap;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_cell_row    <= row;
    in_cell_col    <= col;
    in_write_value <= wr_val;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  // Holds the input idle until every result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Origin of a 6x6 patch, pulled toward the grid edges half of the time.
  function automatic logic [CELL_ADDR_W-1:0] patch_origin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CELL_ADDR_W'(26);
      default: return CELL_ADDR_W'($urandom_range(0, 26));
    endcase
  endfunction

  initial begin
    logic [CELL_ADDR_W-1:0] r0;
    logic [CELL_ADDR_W-1:0] c0;
    int                     n_seed;
    int                     n_step;
    int                     n_read;
    int                     episode;

    in_valid       <= 1'b0;
    in_opcode      <= OP_READ;
    in_cell_row    <= '0;
    in_cell_col    <= '0;
    in_write_value <= 1'b0;
    rst_n          <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Corners and single-cell operations.
    issue_request(OP_WRITE,  5'd0,  5'd0,  1'b1);
    issue_request(OP_READ,   5'd0,  5'd0,  1'b0);
    issue_request(OP_TOGGLE, 5'd31, 5'd31, 1'b0);
    issue_request(OP_READ,   5'd31, 5'd31, 1'b1);
    issue_request(OP_WRITE,  5'd31, 5'd31, 1'b0);
    issue_request(OP_TOGGLE, 5'd0,  5'd31, 1'b1);
    issue_request(OP_WRITE,  5'd31, 5'd0,  1'b1);
    // An L in the corner: the inner cell is born, lone corner cells die.
    issue_request(OP_WRITE,  5'd0,  5'd1,  1'b1);
    issue_request(OP_WRITE,  5'd1,  5'd0,  1'b1);
    issue_request(OP_STEP,   5'd31, 5'd31, 1'b1);
    issue_request(OP_READ,   5'd1,  5'd1,  1'b0);
    issue_request(OP_READ,   5'd0,  5'd31, 1'b0);
    issue_request(OP_READ,   5'd31, 5'd0,  1'b0);
    // A blinker on the bottom edge loses its outer cells against the edge.
    issue_request(OP_WRITE,  5'd31, 5'd14, 1'b1);
    issue_request(OP_WRITE,  5'd31, 5'd15, 1'b1);
    issue_request(OP_WRITE,  5'd31, 5'd16, 1'b1);
    issue_request(OP_STEP,   5'd0,  5'd0,  1'b0);
    issue_request(OP_READ,   5'd30, 5'd15, 1'b0);
    issue_request(OP_READ,   5'd31, 5'd14, 1'b0);
    issue_request(OP_STEP,   5'd17, 5'd9,  1'b1);
    issue_request(OP_READ,   5'd31, 5'd16, 1'b0);
    issue_request(OP_TOGGLE, 5'd1,  5'd1,  1'b1);
    issue_request(OP_WRITE,  5'd0,  5'd0,  1'b0);
    issue_request(OP_READ,   5'd15, 5'd15, 1'b1);

    // Random episodes: seed, step, then probe a patch; or send random requests.
    episode = 0;
    while (sent_cnt < RANDOM_ITEMS) begin
      episode++;
      if (episode % 40 == 20) begin
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 8)) begin
          issue_request(opcode_t'($urandom_range(0, 3)), CELL_ADDR_W'($urandom),
                        CELL_ADDR_W'($urandom), 1'($urandom));
        end
      end else begin
        r0     = patch_origin();
        c0     = patch_origin();
        n_seed = $urandom_range(4, 12);
        n_step = $urandom_range(1, 3);
        n_read = $urandom_range(3, 8);
        repeat (n_seed) begin
          issue_request(($urandom_range(0, 3) == 0) ? OP_TOGGLE : OP_WRITE,
                        r0 + CELL_ADDR_W'($urandom_range(0, 5)),
                        c0 + CELL_ADDR_W'($urandom_range(0, 5)),
                        ($urandom_range(0, 9) < 7));
        end
        repeat (n_step) begin
          issue_request(OP_STEP, CELL_ADDR_W'($urandom), CELL_ADDR_W'($urandom), 1'($urandom));
        end
        repeat (n_read) begin
          issue_request(OP_READ, r0 + CELL_ADDR_W'($urandom_range(0, 5)),
                        c0 + CELL_ADDR_W'($urandom_range(0, 5)), 1'($urandom));
        end
      end
    end

    // Let the last results drain, then allow for one more full generation sweep.
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
